@@ design/quicksort_engine_unit_defines.svh @@
// Assertion macros shared by the quicksort engine RTL.
`ifndef QUICKSORT_ENGINE_UNIT_DEFINES_SVH
`define QUICKSORT_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define QSE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante.
`define QSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QSE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define QSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/qse_pkg.sv @@
// Shared types and constants of the quicksort engine.
package qse_pkg;

   // Width of the value field on both channels.
   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

@@ design/qse_req_if.sv @@
// Input channel of the quicksort engine: one value per beat, last marks the set end.
interface qse_req_if;
   import qse_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

@@ design/qse_rsp_if.sv @@
// Result channel of the quicksort engine: one sorted value per beat.
interface qse_rsp_if;
   import qse_pkg::*;

   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      final_res;

   modport source (output valid, output sorted_value, output final_res, input ready);
   modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

@@ design/qse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
module qse_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS  = 64,
   localparam int ADDR_W = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/quicksort_engine_unit.sv @@
// Quicksort engine: collects signed values, sorts them in place, streams them back ascending.
//
// Load values one beat per cycle on req_port; the engine stores them in an element RAM
// (DEPTH words of WIDTH bits, sign-extended or truncated from 32 bits) and drops any beat
// that arrives once DEPTH values are held, while still honoring its last bit. The beat with
// last set starts the sort and ready stays low until the sorted set has been handed to the
// output register. The sort is quicksort with the first element of each range as pivot and
// Hoare-style partitioning, driven by a small sequencer around one element RAM port pair
// (one read and one write per cycle) and a range stack RAM of DEPTH entries that replaces
// recursion; ranges of fewer than two elements are never pushed. Each scan step of the
// partition is one RAM read and one compare, each swap is two writes and the read that
// resumes the left scan, and each range adds a pop, a pivot fetch, pivot placement and
// pushes. Already ordered input is the worst case, since the first element is the pivot.
// Emission then reads the sorted values in order and hands each to the output register
// whenever it is free; the final value carries final_res. The result sits in an output
// register, so loading of the next set starts while the last sorted value still waits on
// rsp_port. Beats without last give no result. The range stack needs no clearing pass: its
// pointer marks it empty after reset.
module quicksort_engine_unit #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input logic          clock,
   input logic          reset,
   qse_req_if.sink      req_port,
   qse_rsp_if.source    rsp_port
);
   import qse_pkg::*;

`include "quicksort_engine_unit_defines.svh"

   localparam int IDXW = $clog2(DEPTH);      // element index
   localparam int CNTW = $clog2(DEPTH + 1);  // count, stack pointer, right scan index
   localparam int STKW = 2 * IDXW;           // stacked range {lo, hi}

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_WAIT,
      ST_L_ISSUE,
      ST_L_CHK,
      ST_R_CHK,
      ST_SWAP1,
      ST_SWAP2,
      ST_FIN1,
      ST_FIN2,
      ST_PUSH2,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   // Sequencer state and control registers.
   state_type          state_ff,    state_in;
   logic [CNTW-1:0]    count_ff,    count_in;
   logic [CNTW-1:0]    sp_ff,       sp_in;
   logic [IDXW-1:0]    lo_ff,       lo_in;
   logic [IDXW-1:0]    hi_ff,       hi_in;
   logic [IDXW-1:0]    left_ff,     left_in;
   logic [CNTW-1:0]    right_ff,    right_in;
   logic [IDXW-1:0]    emit_ff,     emit_in;
   logic               out_valid_ff, out_valid_in;

   // Payload registers.
   logic [WIDTH-1:0]   pivot_ff,    pivot_in;
   logic [WIDTH-1:0]   lval_ff,     lval_in;
   logic [WIDTH-1:0]   rval_ff,     rval_in;
   value_type          out_value_ff, out_value_in;
   logic               out_final_ff, out_final_in;

   // Element RAM port.
   logic               s_we;
   logic [IDXW-1:0]    s_waddr;
   logic [WIDTH-1:0]   s_wdata;
   logic               s_re;
   logic [IDXW-1:0]    s_raddr;
   logic [WIDTH-1:0]   s_rdata;

   // Range stack RAM port.
   logic               t_we;
   logic [IDXW-1:0]    t_waddr;
   logic [STKW-1:0]    t_wdata;
   logic               t_re;
   logic [IDXW-1:0]    t_raddr;
   logic [STKW-1:0]    t_rdata;

   logic               lt_pivot;   // element read < pivot
   logic               gt_pivot;   // pivot < element read
   logic               out_free;
   logic [IDXW-1:0]    split_at;   // final pivot position of the current range

   qse_ram #(.DATA_W(WIDTH), .WORDS(DEPTH)) u_elem_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   qse_ram #(.DATA_W(STKW), .WORDS(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   // The one shared comparator pair: element just read against the pivot.
   assign lt_pivot = $signed(s_rdata) < $signed(pivot_ff);
   assign gt_pivot = $signed(pivot_ff) < $signed(s_rdata);
   assign out_free = !out_valid_ff || rsp_port.ready;
   assign split_at = right_ff[IDXW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sp_in        = sp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      emit_in      = emit_ff;
      pivot_in     = pivot_ff;
      lval_in      = lval_ff;
      rval_in      = rval_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_final_in = out_final_ff;

      s_we    = 1'b0;
      s_waddr = '0;
      s_wdata = '0;
      s_re    = 1'b0;
      s_raddr = '0;
      t_we    = 1'b0;
      t_waddr = '0;
      t_wdata = '0;
      t_re    = 1'b0;
      t_raddr = '0;

      // drop the output beat once the sink takes it
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_port.valid) begin
               // store while there is room; a full store drops the value
               if (count_ff < CNTW'(DEPTH)) begin
                  s_we     = 1'b1;
                  s_waddr  = count_ff[IDXW-1:0];
                  s_wdata  = WIDTH'(req_port.value);
                  count_in = count_ff + CNTW'(1);
               end
               if (req_port.last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            sp_in = '0;
            if (count_ff >= CNTW'(2)) begin
               // whole set is the first range; fetch its pivot
               lo_in    = '0;
               hi_in    = IDXW'(count_ff - CNTW'(1));
               s_re     = 1'b1;
               s_raddr  = '0;
               state_in = ST_PIV_WAIT;
            end else if (count_ff != '0) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               t_re     = 1'b1;
               t_raddr  = IDXW'(sp_ff - CNTW'(1));
               sp_in    = sp_ff - CNTW'(1);
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            lo_in    = t_rdata[STKW-1:IDXW];
            hi_in    = t_rdata[IDXW-1:0];
            s_re     = 1'b1;
            s_raddr  = t_rdata[STKW-1:IDXW];
            state_in = ST_PIV_WAIT;
         end
         ST_PIV_WAIT: begin
            pivot_in = s_rdata;
            left_in  = lo_ff + IDXW'(1);
            right_in = CNTW'(hi_ff) + CNTW'(1);
            s_re     = 1'b1;
            s_raddr  = lo_ff + IDXW'(1);
            state_in = ST_L_CHK;
         end
         ST_L_ISSUE: begin
            left_in  = left_ff + IDXW'(1);
            s_re     = 1'b1;
            s_raddr  = left_ff + IDXW'(1);
            state_in = ST_L_CHK;
         end
         ST_L_CHK: begin
            if (lt_pivot && (left_ff < hi_ff)) begin
               // advance the left scan
               left_in = left_ff + IDXW'(1);
               s_re    = 1'b1;
               s_raddr = left_ff + IDXW'(1);
            end else begin
               // hold the left element, start the right scan
               lval_in  = s_rdata;
               right_in = right_ff - CNTW'(1);
               s_re     = 1'b1;
               s_raddr  = IDXW'(right_ff - CNTW'(1));
               state_in = ST_R_CHK;
            end
         end
         ST_R_CHK: begin
            if ((right_ff > CNTW'(lo_ff)) && gt_pivot) begin
               right_in = right_ff - CNTW'(1);
               s_re     = 1'b1;
               s_raddr  = IDXW'(right_ff - CNTW'(1));
            end else begin
               rval_in = s_rdata;
               if (CNTW'(left_ff) >= right_ff) begin
                  state_in = ST_FIN1;
               end else begin
                  state_in = ST_SWAP1;
               end
            end
         end
         ST_SWAP1: begin
            s_we     = 1'b1;
            s_waddr  = left_ff;
            s_wdata  = rval_ff;
            state_in = ST_SWAP2;
         end
         ST_SWAP2: begin
            s_we     = 1'b1;
            s_waddr  = split_at;
            s_wdata  = lval_ff;
            state_in = ST_L_ISSUE;
         end
         ST_FIN1: begin
            s_we     = 1'b1;
            s_waddr  = lo_ff;
            s_wdata  = rval_ff;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            // place the pivot and push the right part while the stack port is free
            s_we    = 1'b1;
            s_waddr = split_at;
            s_wdata = pivot_ff;
            if ((CNTW'(split_at) + CNTW'(1) < CNTW'(hi_ff)) && (sp_ff < CNTW'(DEPTH))) begin
               t_we    = 1'b1;
               t_waddr = sp_ff[IDXW-1:0];
               t_wdata = {split_at + IDXW'(1), hi_ff};
               sp_in   = sp_ff + CNTW'(1);
            end
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            // push the left part last so it is handled first
            if ((CNTW'(split_at) > CNTW'(lo_ff) + CNTW'(1)) && (sp_ff < CNTW'(DEPTH))) begin
               t_we    = 1'b1;
               t_waddr = sp_ff[IDXW-1:0];
               t_wdata = {lo_ff, split_at - IDXW'(1)};
               sp_in   = sp_ff + CNTW'(1);
            end
            state_in = ST_POP;
         end
         ST_EMIT_RD: begin
            s_re     = 1'b1;
            s_raddr  = emit_ff;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = VALUE_W'(s_rdata);
               out_final_in = (CNTW'(emit_ff) + CNTW'(1) == count_ff);
               if (CNTW'(emit_ff) + CNTW'(1) == count_ff) begin
                  // set handed off: empty the store and resume loading
                  count_in = '0;
                  sp_in    = '0;
                  state_in = ST_LOAD;
               end else begin
                  emit_in = emit_ff + IDXW'(1);
                  s_re    = 1'b1;
                  s_raddr = emit_ff + IDXW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sp_ff        <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
         pivot_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
         pivot_ff     <= pivot_in;
      end
      lval_ff      <= lval_in;
      rval_ff      <= rval_in;
      out_value_ff <= out_value_in;
      out_final_ff <= out_final_in;
   end

   assign req_port.ready        = (state_ff == ST_LOAD);
   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.sorted_value = out_value_ff;
   assign rsp_port.final_res    = out_final_ff;

   `QSE_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(DEPTH), "element count beyond depth")
   `QSE_ASSERT_IMPLY(a_left_window, clock, reset, state_ff == ST_L_CHK, (left_ff > lo_ff) && (left_ff <= hi_ff), "left scan outside range")
   `QSE_ASSERT_IMPLY(a_right_window, clock, reset, state_ff == ST_R_CHK, (right_ff >= CNTW'(lo_ff)) && (right_ff <= CNTW'(hi_ff)), "right scan outside range")
   `QSE_ASSERT_NEXT(a_pop_step, clock, reset, (state_ff == ST_POP) && (sp_ff != '0), sp_ff == $past(sp_ff) - CNTW'(1), "stack pop did not step pointer")

endmodule

@@ tb/quicksort_engine_unit_tb.sv @@
// Self-checking testbench: streams value sets into the quicksort engine and checks each sorted beat.
module quicksort_engine_unit_tb;
   import qse_pkg::*;

   localparam int DEPTH        = 64;
   localparam int WIDTH        = 32;
   localparam int RANDOM_ITEMS = 400;
   // Allow for the tail of the last sort and a late final beat before calling it done.
   localparam int DRAIN_CYCLES = 100;
   localparam int LIMIT_CYCLES = 600000;

   localparam value_type MAXV = 32'sh7FFF_FFFF;
   localparam value_type MINV = 32'sh8000_0000;
   localparam value_type NEG1 = 32'shFFFF_FFFF;

   // One input beat. typed_n > 0 marks a closing beat whose results are taken from
   // want_a (and want_b) instead of the sorting model.
   typedef struct packed {
      value_type  value;
      logic       last;
      logic [1:0] typed_n;
      value_type  want_a;
      value_type  want_b;
   } req_beat_type;

   typedef struct packed {
      value_type sorted_value;
      logic      final_res;
   } sorted_beat_type;

   // Directed sets: lone extremes, pairs across the sign boundary, duplicates,
   // ordered and reversed runs (the slow case for a first-element pivot).
   localparam req_beat_type DIRECTED [25] = '{
      '{MAXV,          1'b1, 2'd1, MAXV, 32'sd0},
      '{MINV,          1'b1, 2'd1, MINV, 32'sd0},
      '{32'sd0,        1'b1, 2'd1, 32'sd0, 32'sd0},
      '{NEG1,          1'b1, 2'd1, NEG1, 32'sd0},
      '{MAXV,          1'b0, 2'd0, 32'sd0, 32'sd0},
      '{MINV,          1'b1, 2'd2, MINV, MAXV},
      '{32'sd5,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd5,        1'b1, 2'd2, 32'sd5, 32'sd5},
      '{32'sd1,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{NEG1,          1'b1, 2'd2, NEG1, 32'sd1},
      '{MINV,          1'b0, 2'd0, 32'sd0, 32'sd0},
      '{MINV,          1'b1, 2'd2, MINV, MINV},
      '{32'sd1,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd2,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd3,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd4,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd5,        1'b1, 2'd0, 32'sd0, 32'sd0},
      '{32'sd5,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd4,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd3,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd2,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd1,        1'b1, 2'd0, 32'sd0, 32'sd0},
      '{32'sd7,        1'b0, 2'd0, 32'sd0, 32'sd0},
      '{-32'sd7,       1'b0, 2'd0, 32'sd0, 32'sd0},
      '{32'sd0,        1'b1, 2'd0, 32'sd0, 32'sd0}
   };

   logic clock;
   logic reset;

   qse_req_if req ();
   qse_rsp_if rsp ();

   quicksort_engine_unit #(
      .DEPTH(DEPTH),
      .WIDTH(WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req),
      .rsp_port(rsp)
   );

   req_beat_type    stim [$];
   sorted_beat_type sorted_due [$];

   // Model of the engine: the set held so far and its saturating count.
   value_type held [DEPTH];
   int        held_n      = 0;
   int        beats_taken = 0;
   int        faults      = 0;
   int        tail_start  = 0;
   bit        idle_ok     = 1'b1;
   bit        bursty      = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the engine hangs or loses a beat.
   initial begin
      #(LIMIT_CYCLES * 20);
      $display("simulation failed");
      $finish;
   end

   // Count a failure; report only the first few in detail.
   task automatic note_fault(input string what);
      faults++;
      if (faults <= 10)
         $display("%s", what);
   endtask

   // Sort the held set ascending, signed. Any correct sort gives the same order.
   function automatic void sort_held_values();
      value_type key;
      int        j;
      for (int i = 1; i < held_n; i++) begin
         key = held[i];
         j   = i - 1;
         while (j >= 0 && held[j] > key) begin
            held[j + 1] = held[j];
            j--;
         end
         held[j + 1] = key;
      end
   endfunction

   // Build the whole beat list: the directed table, then random sets until the
   // random budget of stored beats is spent.
   task automatic build_stimulus();
      int        kind;
      int        len;
      int        budget;
      int        big_sets;
      int        step;
      bit        rising;
      value_type base;
      value_type v;
      budget   = 0;
      big_sets = 0;
      foreach (DIRECTED[i])
         stim.push_back(DIRECTED[i]);
      while (budget < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         // Keep full and overflowing sets rare: they sort slowly.
         if (kind == 9 && big_sets >= 3)
            kind = 0;
         case (kind)
            6: len = $urandom_range(2, 16);
            7: len = $urandom_range(2, 24);
            8: len = $urandom_range(1, 24);
            9: begin
               len = (big_sets == 0) ? DEPTH : $urandom_range(DEPTH + 1, DEPTH + 6);
               big_sets++;
            end
            default: len = $urandom_range(1, 12);
         endcase
         base   = value_type'($urandom_range(0, 1 << 20)) - (1 << 19);
         step   = $urandom_range(0, 1000);
         rising = $urandom_range(0, 1);
         for (int k = 0; k < len; k++) begin
            case (kind)
               6: v = value_type'($urandom_range(0, 16)) - 8;
               7: v = rising ? base + k * step : base - k * step;
               8: begin
                  case ($urandom_range(0, 4))
                     0: v = MAXV;
                     1: v = MINV;
                     2: v = 32'sd0;
                     3: v = NEG1;
                     default: v = value_type'($urandom);
                  endcase
               end
               default: v = value_type'($urandom);
            endcase
            stim.push_back('{v, (k == len - 1), 2'd0, 32'sd0, 32'sd0});
         end
         // Beats dropped past a full store do not count.
         budget += (len < DEPTH) ? len : DEPTH;
      end
      tail_start = (stim.size() * 9) / 10;
   endtask

   // Source side: hold each beat until taken, with random idle bursts between beats.
   initial begin
      req.valid <= 1'b0;
      req.value <= '0;
      req.last  <= 1'b0;
      reset     <= 1'b1;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < stim.size(); i++) begin
         // Drop all idling near the end so the engine runs at full rate.
         if (i >= tail_start)
            idle_ok = 1'b0;
         if (idle_ok && bursty && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         req.valid <= 1'b1;
         req.value <= stim[i].value;
         req.last  <= stim[i].last;
         do @(posedge clock); while (!req.ready);
         // Pick a new idling mood per set, so some sets run without gaps.
         if (stim[i].last)
            bursty = ($urandom_range(0, 2) != 0);
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Sink side: stall in random bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else if (idle_ok && bursty && $urandom_range(0, 5) == 0) begin
            rsp.ready  <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Monitor: track taken input beats in the model and check every result beat
   // against the oldest pending expectation. One block keeps the order fixed.
   always @(posedge clock) begin
      req_beat_type    row;
      sorted_beat_type due;
      if (!reset) begin
         if (req.valid && req.ready) begin
            row = stim[beats_taken];
            beats_taken++;
            // Store until full; past that only the last bit matters.
            if (held_n < DEPTH) begin
               held[held_n] = req.value;
               held_n++;
            end
            if (req.last) begin
               sort_held_values();
               if (row.typed_n == 2'd0) begin
                  for (int k = 0; k < held_n; k++)
                     sorted_due.push_back('{held[k], (k == held_n - 1)});
               end else begin
                  sorted_due.push_back('{row.want_a, (row.typed_n == 2'd1)});
                  if (row.typed_n == 2'd2)
                     sorted_due.push_back('{row.want_b, 1'b1});
               end
               // Start over with an empty store for the next set.
               held_n = 0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (sorted_due.size() == 0) begin
               note_fault($sformatf("unexpected result beat: value %0d final %0b",
                                    rsp.sorted_value, rsp.final_res));
            end else begin
               due = sorted_due.pop_front();
               if (rsp.sorted_value !== due.sorted_value || rsp.final_res !== due.final_res)
                  note_fault($sformatf("result mismatch: expected %0d final %0b, got %0d final %0b",
                                       due.sorted_value, due.final_res,
                                       rsp.sorted_value, rsp.final_res));
            end
         end
      end
   end

endmodule

@@ files.f @@
+incdir+design
design/qse_pkg.sv
design/qse_req_if.sv
design/qse_rsp_if.sv
design/qse_ram.sv
design/quicksort_engine_unit.sv
tb/quicksort_engine_unit_tb.sv
